// ===== hdl/sobm_pkg.sv =====
// shared types, register codes and constants of the sobel edge magnitude block
package sobm_pkg;

  // line store depth and address width
  localparam int MAX_WIDTH = 4096;
  localparam int LS_AW     = $clog2(MAX_WIDTH);

  // register file reset values
  localparam logic [12:0] IMAGE_WIDTH_RST   = 13'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST  = 16'd480;
  localparam logic [12:0] ACTIVE_WIDTH_RST  = 13'd512;
  localparam logic [15:0] ACTIVE_HEIGHT_RST = 16'd384;
  localparam logic        QUANT_EN_RST      = 1'b1;
  localparam logic [3:0]  SHIFT_AMOUNT_RST  = 4'd2;

  // largest value carried by edge_value
  localparam logic [7:0] EDGE_MAX = 8'd255;

  // register indexes
  localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_ACTIVE_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_ACTIVE_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_QUANTIZE_ENABLE = 3'd4;
  localparam logic [2:0] CFG_SHIFT_AMOUNT    = 3'd5;

  // input word
  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0]  edge_value;
    logic [11:0] out_col;
    logic [15:0] out_row;
    logic        frame_end;
  } out_word_t;

  // register file contents with the effective frame limits
  typedef struct packed {
    logic [11:0] w_m1;
    logic [15:0] h_m1;
    logic [12:0] active_width;
    logic [15:0] active_height;
    logic        quant_en;
    logic [3:0]  shift_amount;
  } cfg_t;

endpackage

// ===== hdl/sobm_ram.sv =====
// generic single write port, single read port ram with registered read
module sobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sobm_cfg.sv =====
// configuration register file and effective frame limits
module sobm_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output sobm_pkg::cfg_t    cfg
);
  import sobm_pkg::*;

  logic [12:0] image_width_r;
  logic [15:0] image_height_r;
  logic [12:0] active_width_r;
  logic [15:0] active_height_r;
  logic        quant_en_r;
  logic [3:0]  shift_amount_r;
  logic        wr;
  logic [11:0] w_m1;
  logic [15:0] h_m1;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= IMAGE_WIDTH_RST;
      image_height_r  <= IMAGE_HEIGHT_RST;
      active_width_r  <= ACTIVE_WIDTH_RST;
      active_height_r <= ACTIVE_HEIGHT_RST;
      quant_en_r      <= QUANT_EN_RST;
      shift_amount_r  <= SHIFT_AMOUNT_RST;
    end else if (wr) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:     image_width_r   <= cfg_data[12:0];
        CFG_IMAGE_HEIGHT:    image_height_r  <= cfg_data;
        CFG_ACTIVE_WIDTH:    active_width_r  <= cfg_data[12:0];
        CFG_ACTIVE_HEIGHT:   active_height_r <= cfg_data;
        CFG_QUANTIZE_ENABLE: quant_en_r      <= cfg_data[0];
        CFG_SHIFT_AMOUNT:    shift_amount_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // last column: width saturated into 3..MAX_WIDTH, minus one
  always_comb begin
    if (image_width_r < 13'd3) begin
      w_m1 = 12'd2;
    end else if (image_width_r > 13'(MAX_WIDTH)) begin
      w_m1 = 12'(MAX_WIDTH - 1);
    end else begin
      w_m1 = 12'(image_width_r - 13'd1);
    end
  end

  // last row: height raised to at least 3, minus one
  assign h_m1 = (image_height_r < 16'd3) ? 16'd2 : (image_height_r - 16'd1);

  assign cfg = {w_m1, h_m1, active_width_r, active_height_r, quant_en_r, shift_amount_r};

endmodule

// ===== hdl/sobm_mag.sv =====
// gradient magnitude: |gx|+|gy|, optional right shift, clamp, active mask
module sobm_mag (
  input  logic signed [10:0] gx,
  input  logic signed [10:0] gy,
  input  logic               mag_en,
  input  sobm_pkg::cfg_t     cfg,
  output logic [7:0]         edge_value
);
  import sobm_pkg::*;

  logic [10:0] abs_x;
  logic [10:0] abs_y;
  logic [10:0] sum;
  logic [10:0] shifted;

  // absolute values, each at most 1020
  assign abs_x = gx[10] ? 11'(-gx) : 11'(gx);
  assign abs_y = gy[10] ? 11'(-gy) : 11'(gy);
  assign sum   = abs_x + abs_y;

  // quantization shift
  assign shifted = cfg.quant_en ? (sum >> cfg.shift_amount) : sum;

  // clamp and mask
  always_comb begin
    if (!mag_en) begin
      edge_value = 8'd0;
    end else if (shifted > 11'(EDGE_MAX)) begin
      edge_value = EDGE_MAX;
    end else begin
      edge_value = shifted[7:0];
    end
  end

endmodule

// ===== hdl/sobel_edge_magnitude_core.sv =====
// top level of the streaming 3x3 sobel edge magnitude block
//
//  channel | ports                                  | direction | flow control
//  --------+----------------------------------------+-----------+--------------
//  in      | in_valid, in_stall, in_data            | in        | valid/stall
//  out     | out_valid, out_stall, out_data         | out       | valid/stall
//  cfg     | cfg_valid, cfg_ready, cfg_index/data   | in        | valid/ready
//
// one pixel word per clock unless stalled; results pass stage 1, stage 2 and
// the output register. the line store rams set the rate: one read, one write
// per pixel, written as it leaves stage 1, forwarded when both hit one entry
// reset clears counters, window and pipeline valids; line stores are not cleared
// out_stall backs up through an output register and a gradient stage, so the
// input keeps flowing while a result waits until the ram stage also holds one
module sobel_edge_magnitude_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sobm_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sobm_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import sobm_pkg::*;

  cfg_t cfg;

  // position counters
  logic [11:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;

  // stage 0 decode
  logic        accept;
  logic [11:0] c_cur;
  logic [15:0] r_cur;
  logic [11:0] x_cur;
  logic [15:0] y_cur;
  logic        emit_cur;
  logic        mag_en_cur;
  logic        fe_cur;
  logic        fwd_hit;

  // stage 1: ram data present
  logic             s1_v_r;
  logic [7:0]       s1_px_r;
  logic [LS_AW-1:0] s1_idx_r;
  logic             s1_emit_r;
  logic             s1_mag_en_r;
  logic [11:0]      s1_col_r;
  logic [15:0]      s1_row_r;
  logic             s1_fe_r;
  logic             fwd_hit_r;
  logic [7:0]       fwd_top_r;
  logic [7:0]       fwd_mid_r;
  logic             s1_adv;
  logic [7:0]       up_rdata;
  logic [7:0]       mid_rdata;
  logic [7:0]       s1_top;
  logic [7:0]       s1_mid;

  // window and gradients
  logic [7:0]        win_r   [9];
  logic [7:0]        win_nxt [9];
  logic signed [10:0] e [9];
  logic signed [10:0] gx_s1;
  logic signed [10:0] gy_s1;

  // stage 2: gradients registered
  logic               s2_v_r;
  logic signed [10:0] s2_gx_r;
  logic signed [10:0] s2_gy_r;
  logic               s2_mag_en_r;
  logic [11:0]        s2_col_r;
  logic [15:0]        s2_row_r;
  logic               s2_fe_r;
  logic [7:0]         edge_s2;

  // output register
  logic      out_valid_r;
  out_word_t out_word_r;

  // stall chain
  logic hold_out;
  logic hold2;
  logic hold1;

  sobm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a stage holds only if it carries a result and the one after it holds
  assign hold_out = out_valid_r && out_stall;
  assign hold2    = s2_v_r && hold_out;
  assign hold1    = s1_v_r && s1_emit_r && hold2;
  assign in_stall = hold1;
  assign accept   = in_valid && !hold1;
  assign s1_adv   = s1_v_r && !hold1;

  // stage 0: position of this pixel and of its window centre
  assign c_cur    = in_data.frame_start ? 12'd0 : col_r;
  assign r_cur    = in_data.frame_start ? 16'd0 : row_r;
  assign x_cur    = c_cur - 12'd1;
  assign y_cur    = r_cur - 16'd1;
  assign emit_cur = (r_cur != 16'd0) && (c_cur != 12'd0) &&
                    (r_cur <= cfg.h_m1) && (c_cur <= cfg.w_m1);
  assign mag_en_cur = (y_cur != 16'd0) && (x_cur != 12'd0) &&
                      ({1'b0, y_cur} + 17'd1 < {1'b0, cfg.active_height}) &&
                      ({1'b0, x_cur} + 13'd1 < cfg.active_width);
  assign fe_cur   = (r_cur == cfg.h_m1) && (c_cur == cfg.w_m1);

  // raster counter step with wrap
  always_comb begin
    col_nxt = c_cur + 12'd1;
    row_nxt = r_cur;
    if (c_cur >= cfg.w_m1) begin
      col_nxt = 12'd0;
      row_nxt = (r_cur >= cfg.h_m1) ? 16'd0 : (r_cur + 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 12'd0;
      row_r <= 16'd0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores: read at accept, written back as the word leaves stage 1
  sobm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ls_upper (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_idx_r),
    .wdata (s1_mid),
    .re    (accept),
    .raddr (c_cur[LS_AW-1:0]),
    .rdata (up_rdata)
  );

  sobm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ls_middle (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_idx_r),
    .wdata (s1_px_r),
    .re    (accept),
    .raddr (c_cur[LS_AW-1:0]),
    .rdata (mid_rdata)
  );

  // same entry read while the previous word writes it: forward
  assign fwd_hit = accept && s1_adv && (c_cur[LS_AW-1:0] == s1_idx_r);

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!hold1) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r     <= in_data.pixel;
      s1_idx_r    <= c_cur[LS_AW-1:0];
      s1_emit_r   <= emit_cur;
      s1_mag_en_r <= mag_en_cur;
      s1_col_r    <= x_cur;
      s1_row_r    <= y_cur;
      s1_fe_r     <= fe_cur;
      fwd_hit_r   <= fwd_hit;
      fwd_top_r   <= s1_mid;
      fwd_mid_r   <= s1_px_r;
    end
  end

  assign s1_top = fwd_hit_r ? fwd_top_r : up_rdata;
  assign s1_mid = fwd_hit_r ? fwd_mid_r : mid_rdata;

  // window shift: columns move left, new column enters on the right
  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = s1_top;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = s1_mid;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // sobel kernels on the shifted window
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = $signed({3'b000, win_nxt[i]});
    end
  end

  assign gx_s1 = (e[2] - e[0]) + ((e[5] - e[3]) <<< 1) + (e[8] - e[6]);
  assign gy_s1 = (e[6] - e[0]) + ((e[7] - e[1]) <<< 1) + (e[8] - e[2]);

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (!hold2) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold2) begin
      s2_gx_r     <= gx_s1;
      s2_gy_r     <= gy_s1;
      s2_mag_en_r <= s1_mag_en_r;
      s2_col_r    <= s1_col_r;
      s2_row_r    <= s1_row_r;
      s2_fe_r     <= s1_fe_r;
    end
  end

  sobm_mag u_mag (
    .gx         (s2_gx_r),
    .gy         (s2_gy_r),
    .mag_en     (s2_mag_en_r),
    .cfg        (cfg),
    .edge_value (edge_s2)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!hold_out) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_out) begin
      out_word_r.edge_value <= edge_s2;
      out_word_r.out_col    <= s2_col_r;
      out_word_r.out_row    <= s2_row_r;
      out_word_r.frame_end  <= s2_fe_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // a forward needs a word in stage 1 the cycle before
  a_fwd_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit |=> fwd_hit_r && s1_v_r && $past(s1_v_r))
    else $error("forward flagged without a preceding word");

  // a read and write of the same entry in one cycle must be forwarded
  a_fwd_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_adv && (c_cur[LS_AW-1:0] == s1_idx_r)) |=> fwd_hit_r)
    else $error("same entry collision not forwarded");

  // centres in row 0 or column 0 carry zero
  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.out_row == 16'd0 || out_data.out_col == 12'd0))
      |-> (out_data.edge_value == 8'd0))
    else $error("nonzero edge value on the frame border");

  // a stage never drops a held result
  a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
    hold2 |=> s2_v_r && out_valid_r)
    else $error("held gradient stage lost its word");

endmodule

// ===== sim/sobel_edge_checker.sv =====
// sobel edge magnitude checker: predicts result words from accepted pixels and compares them
module sobel_edge_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sobm_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sobm_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  fail_count,
  output int                  edges_pending,
  output int                  edges_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import sobm_pkg::*;

  // register copy
  logic [12:0] img_w;
  logic [15:0] img_h;
  logic [12:0] act_w;
  logic [15:0] act_h;
  logic        quant_en;
  logic [3:0]  shift_amt;

  // line stores, window and raster position of the next pixel
  logic [7:0]  upper_line [MAX_WIDTH];
  logic [7:0]  middle_line [MAX_WIDTH];
  logic [7:0]  win [9];
  logic [11:0] col_cnt;
  logic [15:0] row_cnt;

  // expected result words, oldest first
  out_word_t   edge_queue [$];
  int          mismatch_total;
  int          checked_total;

  task automatic report_mismatch(input string what);
    if (mismatch_total < 50) begin
      $display("[%0t] edge check: %s", $time, what);
    end
    mismatch_total++;
  endtask

  // advance the window by one pixel and queue the result word it completes
  task automatic predict_edge_word(input in_word_t px_word);
    int        wd, ht, r, c, x, y, gx, gy, mag;
    logic [7:0] top_px, mid_px;
    out_word_t res;
    wd = (img_w < 3) ? 3 : ((img_w > MAX_WIDTH) ? MAX_WIDTH : int'(img_w));
    ht = (img_h < 3) ? 3 : int'(img_h);
    if (px_word.frame_start) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    r = int'(row_cnt);
    c = int'(col_cnt);

    // line store rotate
    top_px = upper_line[c];
    mid_px = middle_line[c];
    upper_line[c] = mid_px;
    middle_line[c] = px_word.pixel;

    // window shift, newest column on the right
    win[0] = win[1];
    win[1] = win[2];
    win[2] = top_px;
    win[3] = win[4];
    win[4] = win[5];
    win[5] = mid_px;
    win[6] = win[7];
    win[7] = win[8];
    win[8] = px_word.pixel;

    // result for the centre one row and one column behind
    if (r >= 1 && c >= 1 && r <= ht - 1 && c <= wd - 1) begin
      y = r - 1;
      x = c - 1;
      mag = 0;
      if (y >= 1 && x >= 1 && (y + 1) < int'(act_h) && (x + 1) < int'(act_w)) begin
        gx = int'(win[2]) - int'(win[0]) + 2 * (int'(win[5]) - int'(win[3]))
           + int'(win[8]) - int'(win[6]);
        gy = int'(win[6]) - int'(win[0]) + 2 * (int'(win[7]) - int'(win[1]))
           + int'(win[8]) - int'(win[2]);
        mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
        if (quant_en) begin
          mag = mag >> shift_amt;
        end
        if (mag > int'(EDGE_MAX)) begin
          mag = int'(EDGE_MAX);
        end
      end
      res.edge_value = 8'(mag);
      res.out_col    = 12'(x);
      res.out_row    = 16'(y);
      res.frame_end  = (r == ht - 1) && (c == wd - 1);
      edge_queue.push_back(res);
    end

    // raster advance with wrap at the frame edges
    if (c >= wd - 1) begin
      col_cnt = '0;
      row_cnt = (r >= ht - 1) ? 16'd0 : 16'(r + 1);
    end else begin
      col_cnt = 12'(c + 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      img_w     = IMAGE_WIDTH_RST;
      img_h     = IMAGE_HEIGHT_RST;
      act_w     = ACTIVE_WIDTH_RST;
      act_h     = ACTIVE_HEIGHT_RST;
      quant_en  = QUANT_EN_RST;
      shift_amt = SHIFT_AMOUNT_RST;
      col_cnt   = '0;
      row_cnt   = '0;
      for (int i = 0; i < 9; i++) begin
        win[i] = '0;
      end
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      edge_queue.delete();
      mismatch_total = 0;
      checked_total  = 0;
    end else begin
      // result side
      if (out_valid && !out_stall) begin
        if (edge_queue.size() == 0) begin
          report_mismatch($sformatf("result word row %0d col %0d with nothing expected",
                                    out_data.out_row, out_data.out_col));
        end else begin
          out_word_t want;
          want = edge_queue.pop_front();
          if (out_data.edge_value !== want.edge_value) begin
            report_mismatch($sformatf("edge_value %0d, expected %0d at row %0d col %0d",
                                      out_data.edge_value, want.edge_value,
                                      want.out_row, want.out_col));
          end
          if (out_data.out_col !== want.out_col) begin
            report_mismatch($sformatf("out_col %0d, expected %0d",
                                      out_data.out_col, want.out_col));
          end
          if (out_data.out_row !== want.out_row) begin
            report_mismatch($sformatf("out_row %0d, expected %0d",
                                      out_data.out_row, want.out_row));
          end
          if (out_data.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %0b, expected %0b at row %0d col %0d",
                                      out_data.frame_end, want.frame_end,
                                      want.out_row, want.out_col));
          end
          checked_total++;
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:     img_w     = cfg_data[12:0];
          CFG_IMAGE_HEIGHT:    img_h     = cfg_data;
          CFG_ACTIVE_WIDTH:    act_w     = cfg_data[12:0];
          CFG_ACTIVE_HEIGHT:   act_h     = cfg_data;
          CFG_QUANTIZE_ENABLE: quant_en  = cfg_data[0];
          CFG_SHIFT_AMOUNT:    shift_amt = cfg_data[3:0];
          default: ;
        endcase
      end

      // pixel side
      if (in_valid && !in_stall) begin
        predict_edge_word(in_data);
      end
    end
    fail_count    <= mismatch_total;
    edges_pending <= edge_queue.size();
    edges_checked <= checked_total;
  end

endmodule

// ===== sim/sobel_edge_magnitude_core_tb.sv =====
// testbench top of the sobel edge magnitude block: pixel stimulus, register settings, verdict
module sobel_edge_magnitude_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sobm_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int edges_pending;
  int edges_checked;

  // stimulus knobs and bookkeeping
  bit quiet     = 1'b0;
  int gap_pct   = 0;
  int stall_pct = 0;
  int pixels_sent   = 0;
  int settings_done = 0;
  int frame_w;
  int frame_h;
  int stuck_cycles;

  sobel_edge_magnitude_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sobel_edge_checker edge_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .edges_pending (edges_pending),
    .edges_checked (edges_checked)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog on cycles where no word moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // result stall bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one pixel word, with an optional idle burst in front
  task automatic send_pixel(input logic [7:0] px, input logic fs);
    in_word_t w;
    w.pixel       = px;
    w.frame_start = fs;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  // let every expected result come out, then cover the pipeline latency
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (edges_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one register word; valid stays up for back to back writes
  task automatic cfg_put(input logic [2:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register set, block idle
  task automatic apply_settings(input logic [15:0] wr, input logic [15:0] hr,
                                input logic [15:0] awr, input logic [15:0] ahr,
                                input logic [15:0] qr, input logic [15:0] sr);
    cfg_put(CFG_IMAGE_WIDTH, wr);
    cfg_put(CFG_IMAGE_HEIGHT, hr);
    cfg_put(CFG_ACTIVE_WIDTH, awr);
    cfg_put(CFG_ACTIVE_HEIGHT, ahr);
    cfg_put(CFG_QUANTIZE_ENABLE, qr);
    cfg_put(CFG_SHIFT_AMOUNT, sr);
    cfg_valid <= 1'b0;
    frame_w = (wr[12:0] < 3) ? 3 : ((wr[12:0] > MAX_WIDTH) ? MAX_WIDTH : int'(wr[12:0]));
    frame_h = (hr < 3) ? 3 : int'(hr);
    settings_done++;
  endtask

  initial begin
    int          phase, rnd_items, total, cap, frames, k, r, c, w, h, aw, ah, sel;
    logic [15:0] wr, hr, awr, ahr, qr, sr;
    logic [7:0]  px;
    logic        fs;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest frame, no quantization
    apply_settings(16'd3, 16'd3, 16'd3, 16'd3, 16'd0, 16'd0);
    // dark left, bright right: horizontal gradient clamps
    for (k = 0; k < 9; k++) begin
      send_pixel((k % 3 == 2) ? 8'd255 : 8'd0, k == 0);
    end
    // next frame entered by counter wrap alone: vertical gradient clamps
    for (k = 0; k < 9; k++) begin
      send_pixel((k < 3) ? 8'd255 : ((k < 6) ? 8'd128 : 8'd0), 1'b0);
    end
    // quantized magnitude lands below the clamp
    wait_drain();
    apply_settings(16'd3, 16'd3, 16'd3, 16'd3, 16'd1, 16'd3);
    for (k = 0; k < 9; k++) begin
      send_pixel((k % 3 == 2) ? 8'd255 : 8'd0, k == 0);
    end

    // random phases: one register setting each, mostly whole frames
    phase     = 0;
    rnd_items = 0;
    while (rnd_items < 1000) begin
      frames = 1;
      cap    = 1 << 20;
      if (phase == 1) begin
        // full line store width, a short partial frame
        w   = MAX_WIDTH;
        h   = $urandom_range(3, 6);
        cap = 30;
      end else if (phase == 2) begin
        // width register above the line store saturates
        w   = 8191;
        h   = $urandom_range(0, 7);
        cap = 30;
      end else if (phase == 3) begin
        // tallest frame, a dozen rows of it
        w   = $urandom_range(3, 5);
        h   = 65535;
        cap = w * 12;
      end else if (phase % 6 == 5) begin
        w = $urandom_range(24, 64);
        h = $urandom_range(3, 5);
      end else begin
        // small frames, widths and heights below 3 included
        w      = $urandom_range(0, 10);
        h      = $urandom_range(0, 7);
        frames = $urandom_range(1, 3);
      end

      case ($urandom_range(0, 5))
        0:       aw = 0;
        1:       aw = MAX_WIDTH;
        default: aw = $urandom_range(0, (w + 3 > MAX_WIDTH) ? MAX_WIDTH : w + 3);
      endcase
      case ($urandom_range(0, 5))
        0:       ah = 0;
        1:       ah = 65535;
        default: ah = $urandom_range(0, (h + 3 > 65535) ? 65535 : h + 3);
      endcase

      // unused upper data bits carry noise
      wr  = 16'(w);
      wr[15:13] = 3'($urandom);
      hr  = 16'(h);
      awr = 16'(aw);
      awr[15:13] = 3'($urandom);
      ahr = 16'(ah);
      qr  = {15'($urandom), 1'($urandom)};
      sr  = {12'($urandom), 4'($urandom_range(0, 15))};

      quiet     = (rnd_items >= 850);
      gap_pct   = 15 * $urandom_range(0, 3);
      stall_pct = 15 * $urandom_range(0, 3);

      wait_drain();
      apply_settings(wr, hr, awr, ahr, qr, sr);

      total = frames * frame_w * frame_h;
      if (total > cap) begin
        total = cap;
      end
      for (k = 0; k < total; k++) begin
        c = k % frame_w;
        r = (k / frame_w) % frame_h;
        // phase opens a frame; later frames mostly marked, sometimes by wrap; rare stray marks
        fs = (k == 0) || (r == 0 && c == 0 && $urandom_range(0, 99) < 70) ||
             ($urandom_range(0, 149) == 0);
        sel = $urandom_range(0, 19);
        if (sel < 11) begin
          px = 8'($urandom);
        end else if (sel < 16) begin
          px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end else begin
          px = 8'($urandom_range(120, 135));
        end
        send_pixel(px, fs);
        rnd_items++;
      end
      phase++;
    end

    wait_drain();
    $display("covered %0d pixel words and %0d result words over %0d register settings",
             pixels_sent, edges_checked, settings_done);
    $display("frames from 3x3 up to the full line store width and 65535 rows, shifts 0 to 15");
    if (fail_count == 0 && edges_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sobm_pkg.sv
hdl/sobm_ram.sv
hdl/sobm_cfg.sv
hdl/sobm_mag.sv
hdl/sobel_edge_magnitude_core.sv
sim/sobel_edge_checker.sv
sim/sobel_edge_magnitude_core_tb.sv
